/* rtl/terminal_escape_key_decoder_assert.svh */
// Assertion macros for the terminal escape key decoder.
// Used by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define TEKD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TEKD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define TEKD_ASSERT(name, prop, msg)
`define TEKD_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

/* rtl/tekd_pkg.sv */
// Shared types and constants of the terminal escape key decoder.
// Used by the shared arithmetic unit and by the top level sequencer.
package tekd_pkg;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_DOWN  = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_LBRKT = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [15:0] DELETE_PARAM  = 16'd3;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  localparam logic [2:0] KEY_CHAR      = 3'd0;
  localparam logic [2:0] KEY_ENTER     = 3'd1;
  localparam logic [2:0] KEY_BACKSPACE = 3'd2;
  localparam logic [2:0] KEY_UP        = 3'd3;
  localparam logic [2:0] KEY_DOWN      = 3'd4;
  localparam logic [2:0] KEY_RIGHT     = 3'd5;
  localparam logic [2:0] KEY_LEFT      = 3'd6;
  localparam logic [2:0] KEY_DELETE    = 3'd7;

  localparam logic [1:0] PS_NORMAL = 2'd0;
  localparam logic [1:0] PS_ESC    = 2'd1;
  localparam logic [1:0] PS_CSI    = 2'd2;
  localparam logic [1:0] PS_PARAM  = 2'd3;

  typedef enum logic [1:0] {
    ALU_INC_SAT,
    ALU_GT,
    ALU_MAC10
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [15:0] a;
    logic [15:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] value;
    logic        flag;
  } alu_rsp_t;

  function automatic logic normal_emits(input logic [7:0] b);
    normal_emits = (b == CH_CR) || (b == CH_LF) || (b == CH_BS) || (b >= CH_SPACE);
  endfunction

endpackage

/* rtl/tekd_alu.sv */
// Shared arithmetic unit: saturating increment, greater-than compare and
// saturating multiply-by-ten accumulate. Depends on tekd_pkg.
module tekd_alu import tekd_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [19:0] mac;

  assign mac = {1'b0, req_i.a, 3'b000} + {3'b000, req_i.a, 1'b0} + {16'd0, req_i.b[3:0]};

  always_comb begin
    rsp_o = '0;
    case (req_i.op)
      ALU_INC_SAT: begin
        rsp_o.value = (req_i.a == 16'hFFFF) ? req_i.a : req_i.a + 16'd1;
      end
      ALU_GT: begin
        rsp_o.flag = req_i.a > req_i.b;
      end
      ALU_MAC10: begin
        rsp_o.value = (|mac[19:16]) ? 16'hFFFF : mac[15:0];
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule

/* rtl/tekd_seq_buf.sv */
// Buffer of the bytes of a pending escape sequence, one write and one
// registered read port. Self-contained; contents are undefined until written.
module tekd_seq_buf #(
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/terminal_escape_key_decoder.sv */
// Top level of the terminal escape key decoder: sequencer, output register,
// configuration register. Depends on tekd_pkg, tekd_alu and tekd_seq_buf.
//
//   channel  | direction | tdata            | tuser            | tlast
//   s_axis   | in        | [7:0] byte_value | [0] mode         | -
//   m_axis   | out       | [7:0] char_code  | [2:0] event_kind | last
//   cfg      | in        | [15:0] timeout_ticks (write enable only)
//
// A tick visits S_TICK; a byte S_CHECK and S_HANDLE; a parameter digit also S_MAC.
// A stale flush reads each buffered byte through the single buffer read port.
// The sequencer holds a result while the output register is full and tready is low.
// Reset returns the parser to its normal state; the buffer needs no clearing pass.
`include "terminal_escape_key_decoder_assert.svh"

module terminal_escape_key_decoder import tekd_pkg::*; #(
  parameter int SEQ_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_code
  output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int AW = $clog2(SEQ_MAX);
  localparam int CW = $clog2(SEQ_MAX + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_FL_RD  = 3'd3;
  localparam logic [2:0] S_FL_WR  = 3'd4;
  localparam logic [2:0] S_HANDLE = 3'd5;
  localparam logic [2:0] S_MAC    = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [1:0]    ps_q, ps_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] flush_idx_q, flush_idx_d;
  logic [15:0]   fp_val_q, fp_val_d;
  logic          fp_pres_q, fp_pres_d;
  logic          fp_closed_q, fp_closed_d;
  logic [15:0]   idle_q, idle_d;
  logic [15:0]   timeout_q;
  logic [7:0]    byte_q;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_kind_q;
  logic [7:0]    out_code_q;
  logic          out_last_q;

  logic          out_load;
  logic [2:0]    out_kind_n;
  logic [7:0]    out_code_n;
  logic          out_last_n;
  logic          slot_free;
  logic          in_accept;
  logic          is_digit;
  logic          is_semi;
  logic          buf_we;
  logic          buf_re;
  logic [7:0]    buf_rdata;
  logic          flush_end;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;

  tekd_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  tekd_seq_buf #(
    .Depth (SEQ_MAX)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (byte_q),
    .re_i    (buf_re),
    .raddr_i (flush_idx_q[AW-1:0]),
    .rdata_o (buf_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign is_digit      = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign is_semi       = (byte_q == CH_SEMI);
  assign flush_end     = ((flush_idx_q + CW'(1)) == cnt_q);
  assign buf_re        = (state_q == S_FL_RD);

  always_comb begin
    alu_req.op = ALU_GT;
    alu_req.a  = idle_q;
    alu_req.b  = timeout_q;
    case (state_q)
      S_TICK: begin
        alu_req.op = ALU_INC_SAT;
      end
      S_MAC: begin
        alu_req.op = ALU_MAC10;
        alu_req.a  = fp_val_q;
        alu_req.b  = {12'd0, byte_q[3:0]};
      end
      default: begin
        alu_req.op = ALU_GT;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ps_d        = ps_q;
    cnt_d       = cnt_q;
    flush_idx_d = flush_idx_q;
    fp_val_d    = fp_val_q;
    fp_pres_d   = fp_pres_q;
    fp_closed_d = fp_closed_q;
    idle_d      = idle_q;
    buf_we      = 1'b0;
    out_load    = 1'b0;
    out_kind_n  = KEY_CHAR;
    out_code_n  = 8'd0;
    out_last_n  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = s_axis_tuser[0] ? S_TICK : S_CHECK;
        end
      end
      S_TICK: begin
        idle_d  = alu_rsp.value;
        state_d = S_IDLE;
      end
      S_CHECK: begin
        flush_idx_d = '0;
        if ((ps_q != PS_NORMAL) && alu_rsp.flag) begin
          state_d = S_FL_RD;
        end else begin
          state_d = S_HANDLE;
        end
      end
      S_FL_RD: begin
        state_d = S_FL_WR;
      end
      S_FL_WR: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_code_n  = buf_rdata;
          out_last_n  = flush_end && !normal_emits(byte_q);
          flush_idx_d = flush_idx_q + CW'(1);
          if (flush_end) begin
            ps_d        = PS_NORMAL;
            cnt_d       = '0;
            fp_val_d    = '0;
            fp_pres_d   = 1'b0;
            fp_closed_d = 1'b0;
            state_d     = S_HANDLE;
          end else begin
            state_d = S_FL_RD;
          end
        end
      end
      S_HANDLE: begin
        case (ps_q)
          PS_NORMAL: begin
            if (byte_q == CH_ESC) begin
              buf_we = 1'b1;
              cnt_d  = CW'(1);
              ps_d   = PS_ESC;
            end else if ((byte_q == CH_CR) || (byte_q == CH_LF)) begin
              out_load   = 1'b1;
              out_kind_n = KEY_ENTER;
            end else if (byte_q == CH_BS) begin
              out_load   = 1'b1;
              out_kind_n = KEY_BACKSPACE;
            end else if (byte_q >= CH_SPACE) begin
              out_load   = 1'b1;
              out_code_n = byte_q;
            end
          end
          PS_ESC: begin
            if ((byte_q == CH_LBRKT) && (cnt_q < CW'(SEQ_MAX))) begin
              buf_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
              ps_d   = PS_CSI;
            end else begin
              ps_d  = PS_NORMAL;
              cnt_d = '0;
            end
          end
          default: begin
            if (is_digit || is_semi) begin
              if (cnt_q >= CW'(SEQ_MAX)) begin
                ps_d        = PS_NORMAL;
                cnt_d       = '0;
                fp_val_d    = '0;
                fp_pres_d   = 1'b0;
                fp_closed_d = 1'b0;
              end else begin
                buf_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
                ps_d   = PS_PARAM;
                if (is_semi && !fp_closed_q) begin
                  fp_pres_d   = 1'b1;
                  fp_closed_d = 1'b1;
                end
              end
            end else begin
              case (byte_q)
                CH_UP: begin
                  out_load   = 1'b1;
                  out_kind_n = KEY_UP;
                end
                CH_DOWN: begin
                  out_load   = 1'b1;
                  out_kind_n = KEY_DOWN;
                end
                CH_RIGHT: begin
                  out_load   = 1'b1;
                  out_kind_n = KEY_RIGHT;
                end
                CH_LEFT: begin
                  out_load   = 1'b1;
                  out_kind_n = KEY_LEFT;
                end
                CH_TILDE: begin
                  out_load   = fp_pres_q && (fp_val_q == DELETE_PARAM);
                  out_kind_n = KEY_DELETE;
                end
                default: begin
                  out_load = 1'b0;
                end
              endcase
              ps_d        = PS_NORMAL;
              cnt_d       = '0;
              fp_val_d    = '0;
              fp_pres_d   = 1'b0;
              fp_closed_d = 1'b0;
            end
          end
        endcase

        idle_d = '0;
        if (is_digit && (ps_q != PS_NORMAL) && (ps_q != PS_ESC) && !fp_closed_q &&
            (cnt_q < CW'(SEQ_MAX))) begin
          state_d = S_MAC;
        end else begin
          state_d = S_IDLE;
        end

        // A result that finds the output register still full waits here.
        if (out_load && !slot_free) begin
          state_d     = state_q;
          ps_d        = ps_q;
          cnt_d       = cnt_q;
          fp_val_d    = fp_val_q;
          fp_pres_d   = fp_pres_q;
          fp_closed_d = fp_closed_q;
          idle_d      = idle_q;
          buf_we      = 1'b0;
          out_load    = 1'b0;
        end
      end
      S_MAC: begin
        fp_val_d  = alu_rsp.value;
        fp_pres_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ps_q        <= PS_NORMAL;
      cnt_q       <= '0;
      flush_idx_q <= '0;
      fp_val_q    <= '0;
      fp_pres_q   <= 1'b0;
      fp_closed_q <= 1'b0;
      idle_q      <= '0;
      timeout_q   <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ps_q        <= ps_d;
      cnt_q       <= cnt_d;
      flush_idx_q <= flush_idx_d;
      fp_val_q    <= fp_val_d;
      fp_pres_q   <= fp_pres_d;
      fp_closed_q <= fp_closed_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= s_axis_tdata;
    end
    if (out_load) begin
      out_kind_q <= out_kind_n;
      out_code_q <= out_code_n;
      out_last_q <= out_last_n;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  `TEKD_ASSERT(a_cnt_bound, cnt_q <= CW'(SEQ_MAX), "Pending count exceeds the buffer depth.")
  `TEKD_ASSERT(a_cnt_state, (ps_q == PS_NORMAL) == (cnt_q == '0),
               "Pending count disagrees with the parser state.")
  `TEKD_ASSERT(a_flush_idx, ((state_q == S_FL_RD) || (state_q == S_FL_WR)) |-> (flush_idx_q < cnt_q),
               "Flush index runs past the pending bytes.")
  `TEKD_ASSERT_NEXT(a_mac_done, state_q == S_MAC, (state_q == S_IDLE) && fp_pres_q,
                    "Parameter accumulate did not complete the word.")

endmodule
